// ===== rtl/core/sil_pkg.sv =====
// Shared types and constants for the sorted insert list.
// No dependencies; used by every module under rtl/core.
package sil_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 7;
  localparam int ECNT_W    = 7;
  localparam int MID_W     = 6;
  localparam int GRP_SIZE  = 32;

  localparam logic [MID_W-1:0] MID_MAX = 6'd63;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                     operation;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [ECNT_W-1:0]        entry_count;
    logic [MID_W-1:0]         mid_insert_count;
  } out_item_t;

  // Broadcast from the control logic to every cell
  typedef struct packed {
    logic                     ins_en;
    logic                     rd_en;
    logic                     ld;
    logic signed [DATA_W-1:0] value;
  } chain_ctl_t;

endpackage

// ===== rtl/core/sil_cell.sv =====
// One storage cell of the sorted list: holds a single entry.
// Depends on sil_pkg.
module sil_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7,
  parameter int IDX_W = 7
) (
  input  logic                              clk,
  input  sil_pkg::chain_ctl_t               ctl,
  input  logic [CNT_W-1:0]                  count,
  input  logic [IDX_W-1:0]                  pos_idx,
  input  logic                              prev_less,
  input  logic signed [sil_pkg::DATA_W-1:0] prev_entry,
  output logic                              less,
  output logic signed [sil_pkg::DATA_W-1:0] entry,
  output logic                              end_hit,
  output logic [sil_pkg::DATA_W-1:0]        rd_data
);

  logic signed [sil_pkg::DATA_W-1:0] entry_r;
  logic                              occupied;

  assign occupied = CNT_W'(IDX) < count;
  assign less     = occupied && (entry_r < ctl.value);
  // first free slot with everything before it smaller: value lands at the tail
  assign end_hit  = (count == CNT_W'(IDX)) && prev_less;
  assign rd_data  = (ctl.rd_en && (pos_idx == IDX_W'(IDX))) ? entry_r : '0;
  assign entry    = entry_r;

  // first cell not below the value takes it, later cells take their neighbour's
  always_ff @(posedge clk) begin
    if (ctl.ins_en && !less) begin
      entry_r <= prev_less ? ctl.value : prev_entry;
    end
  end

endmodule

// ===== rtl/core/sil_chain.sv =====
// Row of sil_cell instances plus the registered first level of the read tree.
// Depends on sil_pkg and sil_cell.
module sil_chain #(
  parameter int DEPTH = sil_pkg::DEPTH_DEF,
  parameter int CNT_W = 7,
  parameter int IDX_W = 7,
  parameter int NGRP  = 2
) (
  input  logic                                   clk,
  input  sil_pkg::chain_ctl_t                    ctl,
  input  logic [CNT_W-1:0]                       count,
  input  logic [IDX_W-1:0]                       pos_idx,
  output logic                                   at_end,
  output logic [NGRP-1:0][sil_pkg::DATA_W-1:0]   rd_grp
);

  localparam int PAD = NGRP * sil_pkg::GRP_SIZE;

  logic [DEPTH-1:0]                              less_v;
  logic [DEPTH-1:0]                              end_v;
  logic signed [DEPTH-1:0][sil_pkg::DATA_W-1:0]  entry_v;
  logic [DEPTH-1:0][sil_pkg::DATA_W-1:0]         rd_v;
  logic [PAD-1:0][sil_pkg::DATA_W-1:0]           rd_pad;
  logic [NGRP-1:0][sil_pkg::DATA_W-1:0]          grp_or;
  logic [NGRP-1:0][sil_pkg::DATA_W-1:0]          rd_grp_r;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic                              p_less;
    logic signed [sil_pkg::DATA_W-1:0] p_entry;
    if (k == 0) begin : g_head
      assign p_less  = 1'b1;
      assign p_entry = ctl.value;
    end else begin : g_body
      assign p_less  = less_v[k-1];
      assign p_entry = entry_v[k-1];
    end
    sil_cell #(
      .IDX   (k),
      .CNT_W (CNT_W),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count),
      .pos_idx    (pos_idx),
      .prev_less  (p_less),
      .prev_entry (p_entry),
      .less       (less_v[k]),
      .entry      (entry_v[k]),
      .end_hit    (end_v[k]),
      .rd_data    (rd_v[k])
    );
  end

  assign at_end = |end_v;

  always_comb begin
    rd_pad = '0;
    rd_pad[DEPTH-1:0] = rd_v;
    for (int g = 0; g < NGRP; g++) begin
      grp_or[g] = '0;
      for (int j = 0; j < sil_pkg::GRP_SIZE; j++) begin
        grp_or[g] = grp_or[g] | rd_pad[g*sil_pkg::GRP_SIZE + j];
      end
    end
  end

  // held while the transfer waits downstream
  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      rd_grp_r <= grp_or;
    end
  end

  assign rd_grp = rd_grp_r;

endmodule

// ===== rtl/core/sorted_insert_list_unit.sv =====
// Sorted insert list: keeps up to DEPTH signed 32-bit values in ascending order.
// Depends on sil_pkg, sil_chain and sil_cell.
//
// Input channel in_valid/in_stall/in_data carries one item: operation 0 inserts
// value ahead of the first stored value not below it, operation 1 reads the
// entry at 1-based position. Output channel out_valid/out_stall/out_data gives
// exactly one result per item: status, read value, entry count, mid-insert count.
// A transfer happens on a rising edge with valid high and stall low.
// The transfer edge updates the cells, the first read-tree level and the middle
// stage; the output register and out_valid load from it once the output is free.
// Throughput: one item per cycle while out_stall is low; every cell compares and
// shifts in the cycle the item is taken, so the chain is never the limit.
// When out_stall is held, one result waits in the output register and one more
// in the middle stage; in_stall then rises until the output drains.
// Reset (rst_n low, synchronous) empties the list and clears the mid-insert count.
// Cell contents are not cleared; no pass is needed after reset and the first item
// may be offered on the cycle after reset is released.
module sorted_insert_list_unit #(
  parameter int DEPTH = sil_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sil_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sil_pkg::out_item_t out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (CNT_W > sil_pkg::POS_W) ? CNT_W : sil_pkg::POS_W;
  localparam int NGRP  = (DEPTH + sil_pkg::GRP_SIZE - 1) / sil_pkg::GRP_SIZE;

  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [sil_pkg::MID_W-1:0]      mid_r, mid_nxt;
  logic                           s1_valid_r, s1_valid_nxt;
  logic [1:0]                     s1_status_r;
  logic                           s1_rd_en_r;
  logic [sil_pkg::ECNT_W-1:0]     s1_ecnt_r;
  logic [sil_pkg::MID_W-1:0]      s1_mid_r;
  logic                           out_valid_r, out_valid_nxt;
  sil_pkg::out_item_t             out_data_r;

  sil_pkg::chain_ctl_t            ctl;
  logic                           out_free, s1_adv, in_acc, is_ins, full, in_range;
  logic                           at_end;
  logic [IDX_W-1:0]               pos_ext, cnt_ext, pos_idx;
  logic [1:0]                     status;
  logic [NGRP-1:0][sil_pkg::DATA_W-1:0] rd_grp;
  logic [sil_pkg::DATA_W-1:0]     rd_or;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign is_ins   = in_data.operation == sil_pkg::OP_INSERT;
  assign full     = count_r == CNT_W'(DEPTH);
  assign pos_ext  = IDX_W'(in_data.position);
  assign cnt_ext  = IDX_W'(count_r);
  assign in_range = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign pos_idx  = pos_ext - IDX_W'(1);

  always_comb begin
    ctl.ins_en = in_acc && is_ins && !full;
    ctl.rd_en  = in_acc && !is_ins && in_range;
    ctl.ld     = in_acc;
    ctl.value  = in_data.value;
  end

  sil_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .IDX_W (IDX_W),
    .NGRP  (NGRP)
  ) u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .count   (count_r),
    .pos_idx (pos_idx),
    .at_end  (at_end),
    .rd_grp  (rd_grp)
  );

  always_comb begin
    count_nxt = count_r + CNT_W'(ctl.ins_en);
    mid_nxt   = mid_r;
    if (ctl.ins_en && !at_end && (mid_r != sil_pkg::MID_MAX)) begin
      mid_nxt = mid_r + sil_pkg::MID_W'(1);
    end
    if (is_ins) begin
      status = full ? sil_pkg::ST_FULL : sil_pkg::ST_OK;
    end else begin
      status = in_range ? sil_pkg::ST_OK : sil_pkg::ST_RANGE;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  // second level of the read tree
  always_comb begin
    rd_or = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_or = rd_or | rd_grp[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      mid_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      mid_r       <= mid_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_status_r <= status;
      s1_rd_en_r  <= ctl.rd_en;
      s1_ecnt_r   <= sil_pkg::ECNT_W'(count_nxt);
      s1_mid_r    <= mid_nxt;
    end
    if (s1_adv) begin
      out_data_r.status           <= s1_status_r;
      out_data_r.read_value       <= s1_rd_en_r ? rd_or : '0;
      out_data_r.entry_count      <= s1_ecnt_r;
      out_data_r.mid_insert_count <= s1_mid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_mid_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    IDX_W'(mid_r) <= IDX_W'(count_r))
    else $error("mid-insert count exceeds entry count");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_status_r)
                                   && $stable(s1_ecnt_r)))
    else $error("middle stage lost a waiting item");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != sil_pkg::ST_OK))
      |-> (out_data_r.read_value == '0))
    else $error("failed item carries a read value");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for sorted_insert_list_unit: random and directed inserts and finds.
// A queue-fed driver and a monitor compare every result with an in-bench list predictor.
// Depends on sil_pkg and the RTL under rtl/core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sil_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int N_RANDOM    = 1100;
  localparam int HOLD_AT     = 250;   // results seen before the long receiver hold-off
  localparam int HOLD_LEN    = 60;
  localparam int PAUSE_AT    = 800;   // transfers before the sender waits for a full drain
  localparam int WATCHDOG    = 2000;
  localparam int DRAIN_WAIT  = 8;
  localparam int MAX_REPORTS = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // predictor state
  logic signed [DATA_W-1:0] store_vals [DEPTH];
  int                       store_len = 0;
  logic [MID_W-1:0]         mid_total = '0;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int        n_accepted = 0;
  int        n_results = 0;
  int        n_mismatch = 0;
  bit        pause_done = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  sorted_insert_list_unit #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    int        slot;
    int        k;
    r = '0;
    r.status = ST_OK;
    if (it.operation == OP_INSERT) begin
      if (store_len >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // equal values go ahead of those already stored
        slot = 0;
        while (slot < store_len && $signed(store_vals[slot]) < $signed(it.value)) slot++;
        if (slot < store_len && mid_total != MID_MAX) mid_total++;
        for (k = store_len; k > slot; k--) store_vals[k] = store_vals[k-1];
        store_vals[slot] = it.value;
        store_len++;
      end
    end else if (it.position < 1 || it.position > store_len) begin
      r.status = ST_RANGE;
    end else begin
      r.read_value = store_vals[it.position - 1];
    end
    r.entry_count = ECNT_W'(store_len);
    r.mid_insert_count = mid_total;
    return r;
  endfunction

  function automatic in_item_t make_item(logic op, logic [DATA_W-1:0] val,
                                         logic [POS_W-1:0] pos);
    in_item_t it;
    it.operation = op;
    it.value = val;
    it.position = pos;
    return it;
  endfunction

  function automatic void queue_item(in_item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic void expect_result(out_item_t r);
    expected_results = {expected_results, r};
  endfunction

  // skewed towards duplicates and extremes so ties and list ends get exercised
  function automatic logic [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) return DATA_W'($signed($urandom_range(4)) - 2);
    if (sel < 30) return 32'h7fff_ffff;
    if (sel < 35) return 32'h8000_0000;
    return $urandom;
  endfunction

  task automatic report_mismatch(string what, out_item_t want, out_item_t got);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS)
      $display("[%0t] %s: expected st=%0d rd=%0d cnt=%0d mid=%0d, got st=%0d rd=%0d cnt=%0d mid=%0d",
               $realtime, what, want.status, want.read_value, want.entry_count,
               want.mid_insert_count, got.status, got.read_value, got.entry_count,
               got.mid_insert_count);
  endtask

  // driver
  always @(posedge clk) begin
    int  acc;
    bit  waiting;
    bit  idle;
    acc = n_accepted;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expect_result(predict_result(in_data));
        acc = n_accepted + 1;
        n_accepted <= acc;
      end
      waiting = acc >= PAUSE_AT && !pause_done;
      if (waiting && n_results == acc) pause_done <= 1'b1;
      idle = !(acc >= 300 && acc < 550) && $urandom_range(99) < 11;
      if (in_valid && in_stall) begin
        // stalled payload stays put
      end else if (pending_items.size() > 0 && !waiting && !idle) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results <= n_results + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status || out_data.read_value !== want.read_value ||
              out_data.entry_count !== want.entry_count ||
              out_data.mid_insert_count !== want.mid_insert_count)
            report_mismatch("result mismatch", want, out_data);
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (n_results >= HOLD_AT && !hold_done) begin
        // long hold-off so the unit fills and back-pressures its input
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(n_results >= 700 && n_results < 950) && $urandom_range(99) < 11;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int gen_len;
    int sel;
    logic [POS_W-1:0] pos;

    // directed: empty finds, list ends, ties, range edges, unused fields at all ones
    queue_item(make_item(OP_FIND, 32'h0, 7'd0));
    queue_item(make_item(OP_FIND, 32'hffff_ffff, 7'd1));
    queue_item(make_item(OP_INSERT, 32'h0, 7'h7f));
    queue_item(make_item(OP_INSERT, 32'h7fff_ffff, 7'd0));
    queue_item(make_item(OP_INSERT, 32'h8000_0000, 7'd0));
    queue_item(make_item(OP_INSERT, 32'h0, 7'd0));
    queue_item(make_item(OP_INSERT, 32'hffff_ffff, 7'd0));
    queue_item(make_item(OP_INSERT, 32'h1, 7'd0));
    queue_item(make_item(OP_INSERT, 32'h7fff_ffff, 7'd0));
    queue_item(make_item(OP_INSERT, 32'h8000_0000, 7'd0));
    queue_item(make_item(OP_FIND, 32'h0, 7'd1));
    queue_item(make_item(OP_FIND, 32'h0, 7'd4));
    queue_item(make_item(OP_FIND, 32'h0, 7'd8));
    queue_item(make_item(OP_FIND, 32'h0, 7'd9));
    queue_item(make_item(OP_FIND, 32'hffff_ffff, 7'h7f));
    queue_item(make_item(OP_FIND, 32'h0, 7'd0));
    queue_item(make_item(OP_FIND, 32'h0, 7'd64));
    gen_len = 8;

    // random: fill to the top with mixed finds, then mostly finds plus refused inserts
    for (int n = 0; n < N_RANDOM; n++) begin
      sel = $urandom_range(99);
      if ((gen_len < DEPTH && sel < 45) || (gen_len >= DEPTH && sel < 15)) begin
        queue_item(make_item(OP_INSERT, pick_value(), POS_W'($urandom)));
        if (gen_len < DEPTH) gen_len++;
      end else begin
        sel = $urandom_range(99);
        if (sel < 80) pos = POS_W'($urandom_range(gen_len, 1));
        else if (sel < 90) pos = $urandom_range(1) ? POS_W'(gen_len + 1) : '0;
        else pos = POS_W'($urandom);
        queue_item(make_item(OP_FIND, $urandom, pos));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
